// ===== rtl/core/ubsmc_pkg.sv =====
`timescale 1ns / 1ps

package ubsmc_pkg;

  localparam int unsigned PollWidth    = 16;
  localparam int unsigned TimeoutWidth = 20;
  localparam int unsigned ReadWidth    = 16;
  localparam int unsigned CfgDataWidth = 20;
  localparam int unsigned InTdataWidth = 16;
  localparam int unsigned OutTdataWidth = 32;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [PollWidth-1:0]    PollReset    = 16'd500;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 20'd45000;
  localparam logic [PollWidth-1:0]    PollMax      = 16'hFFFF;
  localparam logic [TimeoutWidth-1:0] TimeoutMax   = 20'hFFFFF;

  localparam logic [7:0] SyncByte      = 8'hFF;
  localparam logic [7:0] PktStatus     = 8'h85;
  localparam logic [7:0] PktResult     = 8'h86;
  localparam logic [7:0] SensIdle      = 8'h31;
  localparam logic [7:0] SensWarming   = 8'h32;
  localparam logic [7:0] SensReady     = 8'h33;
  localparam logic [7:0] SensBlowing   = 8'h34;
  localparam logic [7:0] SensWeak      = 8'h35;
  localparam logic [7:0] SensAnalyzing = 8'h36;
  localparam logic [7:0] SensFinal     = 8'h37;

  localparam logic [3:0] FrameHunt = 4'd0;
  localparam logic [3:0] FrameBody = 4'd7;
  localparam logic [3:0] FrameSum  = 4'd8;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_START = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_POLL    = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_WARMING   = 4'd1,
    ST_READY     = 4'd2,
    ST_BLOWING   = 4'd3,
    ST_WEAK      = 4'd4,
    ST_ANALYZING = 4'd5,
    ST_DONE      = 4'd6,
    ST_TIMEOUT   = 4'd7,
    ST_ERROR     = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_QUERY  = 3'd1,
    CMD_RESULT = 3'd2,
    CMD_START  = 3'd3,
    CMD_IDLE   = 3'd4
  } cmd_e;

  typedef struct packed {
    action_e    op;
    logic       is_sync;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    cmd_e           cmd;
    logic [ReadWidth-1:0] reading;
    logic           finished;
    logic           measuring;
    status_e        status;
  } result_t;

endpackage

// ===== rtl/core/ubsmc_front.sv =====
`timescale 1ns / 1ps

module ubsmc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ubsmc_pkg::InTdataWidth-1:0]  s_tdata,   // action[1:0], rx_byte[9:2]
  output logic                                push_o,
  output ubsmc_pkg::item_t                    item_o,
  input  logic                                room_i
);
  import ubsmc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign s_tready = !valid_q || room_i;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    item_d         = item_q;
    item_d.op      = action_e'(s_tdata[1:0]);
    item_d.data    = s_tdata[9:2];
    item_d.is_sync = (s_tdata[9:2] == SyncByte);
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (room_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_o = valid_q && room_i;
  assign item_o = item_q;

endmodule

// ===== rtl/core/ubsmc_queue.sv =====
`timescale 1ns / 1ps

module ubsmc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ubsmc_pkg::item_t item_i,
  output logic             room_o,
  input  logic             pop_i,
  output logic             avail_o,
  output ubsmc_pkg::item_t item_o
);
  import ubsmc_pkg::*;

  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  item_t               mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign room_o  = (cnt_q != CntWidth'(QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && avail_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? PtrWidth'((32'(wr_q) + 1) % QueueDepth) : wr_q;
    rd_d  = do_pop ? PtrWidth'((32'(rd_q) + 1) % QueueDepth) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(QueueDepth)) else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not advance");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q)) else $error("pointers apart on empty queue");

endmodule

// ===== rtl/core/ubsmc_back.sv =====
`timescale 1ns / 1ps

module ubsmc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 avail_i,
  input  ubsmc_pkg::item_t                     item_i,
  output logic                                 pop_o,
  input  logic                                 cfg_valid,
  input  ubsmc_pkg::cfg_idx_e                  cfg_index,
  input  logic [ubsmc_pkg::CfgDataWidth-1:0]   cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output ubsmc_pkg::result_t                   result_o
);
  import ubsmc_pkg::*;

  logic [PollWidth-1:0]    poll_q;
  logic [TimeoutWidth-1:0] tmo_q;

  status_e                 status_q, status_d;
  logic                    run_q, run_d;
  logic                    fin_q, fin_d;
  logic [ReadWidth-1:0]    read_q, read_d;
  logic [TimeoutWidth-1:0] elap_q, elap_d;
  logic [PollWidth-1:0]    tsp_q, tsp_d;
  logic [3:0]              fpos_q, fpos_d;
  logic [7:0]              sum_q, sum_d;
  logic [7:0]              ptype_q, pb1_q, pb2_q;
  logic                    wr_type, wr_b1, wr_b2;
  cmd_e                    cmd_d;

  logic                    out_valid_q;
  result_t                 out_q;

  logic [TimeoutWidth-1:0] elap_inc;
  logic [PollWidth-1:0]    tsp_inc;

  assign pop_o    = avail_i && (!out_valid_q || m_tready);
  assign elap_inc = (elap_q == TimeoutMax) ? elap_q : elap_q + 1'b1;
  assign tsp_inc  = (tsp_q == PollMax) ? tsp_q : tsp_q + 1'b1;

  always_comb begin
    status_d = status_q;
    run_d    = run_q;
    fin_d    = fin_q;
    read_d   = read_q;
    elap_d   = elap_q;
    tsp_d    = tsp_q;
    fpos_d   = fpos_q;
    sum_d    = sum_q;
    cmd_d    = CMD_NONE;
    wr_type  = 1'b0;
    wr_b1    = 1'b0;
    wr_b2    = 1'b0;
    unique case (item_i.op)
      ACT_TICK: begin
        if (run_q) begin
          elap_d = elap_inc;
          if (elap_inc > tmo_q) begin
            status_d = ST_TIMEOUT;
            run_d    = 1'b0;
            fin_d    = 1'b1;
            cmd_d    = CMD_IDLE;
          end else if (tsp_inc >= poll_q) begin
            tsp_d = '0;
            cmd_d = CMD_QUERY;
          end else begin
            tsp_d = tsp_inc;
          end
        end
      end
      ACT_BYTE: begin
        if (run_q) begin
          if (fpos_q == FrameHunt) begin
            if (item_i.is_sync) begin
              fpos_d = 4'd1;
              sum_d  = '0;
            end
          end else if (fpos_q <= FrameBody) begin
            fpos_d  = fpos_q + 1'b1;
            sum_d   = sum_q + item_i.data;
            wr_type = (fpos_q == 4'd1);
            wr_b1   = (fpos_q == 4'd2);
            wr_b2   = (fpos_q == 4'd3);
          end else begin
            fpos_d = FrameHunt;
            if (8'(sum_q + item_i.data) == 8'd0) begin
              if (ptype_q == PktStatus) begin
                case (pb1_q)
                  SensIdle:      status_d = ST_IDLE;
                  SensWarming:   status_d = ST_WARMING;
                  SensReady:     status_d = ST_READY;
                  SensBlowing:   status_d = ST_BLOWING;
                  SensWeak:      status_d = ST_WEAK;
                  SensAnalyzing: status_d = ST_ANALYZING;
                  SensFinal: begin
                    status_d = ST_ANALYZING;
                    cmd_d    = CMD_RESULT;
                  end
                  default:       status_d = ST_ERROR;
                endcase
              end else if (ptype_q == PktResult) begin
                read_d   = {pb1_q, pb2_q};
                status_d = ST_DONE;
                run_d    = 1'b0;
                fin_d    = 1'b1;
                cmd_d    = CMD_IDLE;
              end
            end
          end
        end
      end
      ACT_START: begin
        read_d   = '0;
        elap_d   = '0;
        tsp_d    = PollMax;
        fpos_d   = FrameHunt;
        status_d = ST_WARMING;
        run_d    = 1'b1;
        fin_d    = 1'b0;
        cmd_d    = CMD_START;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q      <= PollReset;
      tmo_q       <= TimeoutReset;
      status_q    <= ST_IDLE;
      run_q       <= 1'b0;
      fin_q       <= 1'b1;
      read_q      <= '0;
      elap_q      <= '0;
      tsp_q       <= '0;
      fpos_q      <= FrameHunt;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_POLL:    poll_q <= cfg_data[PollWidth-1:0];
          CFG_TIMEOUT: tmo_q  <= cfg_data[TimeoutWidth-1:0];
          default: begin
          end
        endcase
      end
      if (pop_o) begin
        status_q    <= status_d;
        run_q       <= run_d;
        fin_q       <= fin_d;
        read_q      <= read_d;
        elap_q      <= elap_d;
        tsp_q       <= tsp_d;
        fpos_q      <= fpos_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.status    <= status_d;
      out_q.measuring <= run_d;
      out_q.finished  <= fin_d;
      out_q.reading   <= read_d;
      out_q.cmd       <= cmd_d;
      if (wr_type) begin
        ptype_q <= item_i.data;
      end
      if (wr_b1) begin
        pb1_q <= item_i.data;
      end
      if (wr_b2) begin
        pb2_q <= item_i.data;
      end
    end
  end

  assign m_tvalid = out_valid_q;
  assign result_o = out_q;

  a_run_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && fin_q)) else $error("running and finished both set");
  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpos_q <= FrameSum) else $error("frame position out of range");
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.op == ACT_START) |=> (run_q && out_q.cmd == CMD_START))
    else $error("start did not begin a measurement");
  a_idle_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_d == CMD_IDLE) |=> (!run_q && fin_q))
    else $error("idle command while still running");

endmodule

// ===== rtl/core/uart_breath_sensor_measurement_control_core.sv =====
`timescale 1ns / 1ps
// A result is registered in turn by the front-end holding register, the queue and the back-end
// output register. Throughput: one item per cycle while m_axis_tready does not hold the output;
// each item is retired by one update of the measurement state in the back end.
// Reset (rst_ni low, asynchronous): idle status, finished set, counters and reading
// cleared, framer hunting for sync, registers back to 500 and 45000 ticks.
module uart_breath_sensor_measurement_control_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ubsmc_pkg::InTdataWidth-1:0]    s_axis_tdata,   // action[1:0], rx_byte[9:2]
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ubsmc_pkg::OutTdataWidth-1:0]   m_axis_tdata,   // status[3:0], measuring[4],
                                                                // finished[5], reading[21:6],
                                                                // send_command[24:22]
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [ubsmc_pkg::CfgDataWidth-1:0]    cfg_data
);
  import ubsmc_pkg::*;

  item_t   fq_item, qb_item;
  logic    fq_push, fq_room, qb_avail, qb_pop;
  result_t result;

  assign cfg_ready = 1'b1;

  ubsmc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_tdata  (s_axis_tdata),
    .push_o   (fq_push),
    .item_o   (fq_item),
    .room_i   (fq_room)
  );

  ubsmc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .room_o  (fq_room),
    .pop_i   (qb_pop),
    .avail_o (qb_avail),
    .item_o  (qb_item)
  );

  ubsmc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .avail_i   (qb_avail),
    .item_i    (qb_item),
    .pop_o     (qb_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_idx_e'(cfg_index)),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .result_o  (result)
  );

  assign m_axis_tdata = {7'd0, result.cmd, result.reading, result.finished,
                         result.measuring, result.status};

endmodule
